### rtl/stb_pkg.sv
// Shared definitions for the sparse-table range-minimum engine.
// Holds the command codes, the controller states and the fixed field widths.
// No dependencies.
package stb_pkg;

    localparam int IDX_W = 10;
    localparam int LEN_W = 11;
    localparam int IN_W  = 32;
    localparam int OUT_W = 32;

    typedef enum logic {
        CMD_APPEND = 1'b0,
        CMD_QUERY  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALVL,
        S_QDEC,
        S_QRD1,
        S_QRD2,
        S_QMIN,
        S_QOUT
    } t_state;

endpackage

### rtl/stb_mem.sv
// Simple dual-port table memory: one write port, one read port, registered read data.
// Holds every level of the sparse table. No package dependencies.
module stb_mem #(
    parameter int ENTRIES = 22,
    parameter int DW      = 32,
    parameter int AW      = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [ENTRIES];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/stb_qdec.sv
// Query decoder: orders the two range ends, checks them against the loaded count,
// and derives the lookup level and the second lookup position. Uses stb_pkg.
module stb_qdec
    import stb_pkg::*;
#(
    parameter int LEVELS = 11,
    parameter int CW     = 11,
    parameter int KW     = 4
) (
    input  logic [IDX_W-1:0] i_a,
    input  logic [IDX_W-1:0] i_b,
    input  logic [CW-1:0]    i_count,
    output logic [IDX_W-1:0] o_lo,
    output logic [IDX_W-1:0] o_second,
    output logic [KW-1:0]    o_k,
    output logic             o_err
);

    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [LEN_W-1:0] len;
    logic [3:0]       lg;
    logic [KW-1:0]    k;
    logic [LEN_W-1:0] span;
    logic [LEN_W-1:0] sec;

    always_comb begin
        lo  = (i_a < i_b) ? i_a : i_b;
        hi  = (i_a < i_b) ? i_b : i_a;
        len = {1'b0, hi} - {1'b0, lo} + LEN_W'(1);
        lg  = '0;
        for (int i = 1; i < LEN_W; i++) begin
            if (len[i]) begin
                lg = 4'(i);
            end
        end
        if (32'(lg) > LEVELS - 1) begin
            k = KW'(LEVELS - 1);
        end else begin
            k = KW'(lg);
        end
        span = LEN_W'(1) << k;
        sec  = {1'b0, hi} + LEN_W'(1) - span;
    end

    assign o_lo     = lo;
    assign o_second = sec[IDX_W-1:0];
    assign o_k      = k;
    assign o_err    = CMPW'(hi) >= CMPW'(i_count);

endmodule

### rtl/sparse_table_range_min.sv
// Sparse-table range-minimum engine: an append transaction stores a value at the next
// position and then fills one table level per cycle, so it occupies the block until
// every level whose window ends at the new position is filled (the single write and
// single read port of the table memory setting the pace). A query transaction passes
// through decode, two table reads, the minimum and the output stage, or skips the second
// read and the minimum when the range reaches past the loaded data. Its result moves into
// an output register once that register is free, and the next transaction can start then.
// The table memory needs no clearing after reset, as no unwritten entry is ever used.
module sparse_table_range_min
    import stb_pkg::*;
#(
    parameter int DEPTH       = 1024,
    parameter int LEVELS      = 11,
    parameter int VALUE_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_cmd,
    input  logic [IN_W-1:0]  i_value,
    input  logic [IDX_W-1:0] i_left_index,
    input  logic [IDX_W-1:0] i_right_index,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [OUT_W-1:0] o_min_value,
    output logic             o_range_error
);

    localparam int ENTRIES = LEVELS * DEPTH;
    localparam int AW      = $clog2(ENTRIES);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int PW      = $clog2(DEPTH);
    localparam int KW      = $clog2(LEVELS);
    localparam int SPW     = LEVELS;
    localparam int CMP2    = (PW > SPW) ? PW : SPW;
    localparam int VW      = VALUE_WIDTH;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_out_valid, n_out_valid;
    logic [PW-1:0]     r_start, n_start;
    logic [SPW-1:0]    r_span, n_span;
    logic [KW-1:0]     r_k, n_k;
    logic [AW-1:0]     r_rbase, n_rbase;
    logic [VW-1:0]     r_carry, n_carry;
    logic [IDX_W-1:0]  r_a, n_a;
    logic [IDX_W-1:0]  r_b, n_b;
    logic [IDX_W-1:0]  r_lo, n_lo;
    logic [IDX_W-1:0]  r_sec, n_sec;
    logic [KW-1:0]     r_qk, n_qk;
    logic              r_qerr, n_qerr;
    logic [OUT_W-1:0]  r_min_value, n_min_value;
    logic              r_range_error, n_range_error;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [VW-1:0]     mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [VW-1:0]     mem_rdata;

    logic [IDX_W-1:0]  qd_lo;
    logic [IDX_W-1:0]  qd_sec;
    logic [KW-1:0]     qd_k;
    logic              qd_err;

    logic              in_fire;
    logic [AW-1:0]     wbase;
    logic [AW-1:0]     kbase;
    logic [VW-1:0]     lvl_min;
    logic              lvl_more;
    logic [CMP2-1:0]   start_diff;

    stb_mem #(
        .ENTRIES(ENTRIES),
        .DW     (VW),
        .AW     (AW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    stb_qdec #(
        .LEVELS(LEVELS),
        .CW    (CW),
        .KW    (KW)
    ) u_qdec (
        .i_a     (r_a),
        .i_b     (r_b),
        .i_count (r_count),
        .o_lo    (qd_lo),
        .o_second(qd_sec),
        .o_k     (qd_k),
        .o_err   (qd_err)
    );

    assign o_in_ready    = (r_state == S_IDLE);
    assign in_fire       = i_in_valid && o_in_ready;
    assign wbase         = r_rbase + AW'(DEPTH);
    assign kbase         = AW'(r_qk) * AW'(DEPTH);
    assign lvl_min       = (mem_rdata < r_carry) ? mem_rdata : r_carry;
    assign start_diff    = CMP2'(r_start) - CMP2'(r_span);
    assign lvl_more      = (r_k != KW'(LEVELS - 1)) && (CMP2'(r_start) >= CMP2'(r_span));

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_out_valid   = r_out_valid;
        n_start       = r_start;
        n_span        = r_span;
        n_k           = r_k;
        n_rbase       = r_rbase;
        n_carry       = r_carry;
        n_a           = r_a;
        n_b           = r_b;
        n_lo          = r_lo;
        n_sec         = r_sec;
        n_qk          = r_qk;
        n_qerr        = r_qerr;
        n_min_value   = r_min_value;
        n_range_error = r_range_error;
        mem_we        = 1'b0;
        mem_waddr     = AW'(r_count);
        mem_wdata     = VW'(i_value);
        mem_raddr     = AW'(r_count - CW'(1));

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (t_cmd'(i_cmd) == CMD_QUERY) begin
                        n_a     = i_left_index;
                        n_b     = i_right_index;
                        n_state = S_QDEC;
                    end else if (r_count != CW'(DEPTH)) begin
                        mem_we  = 1'b1;
                        n_count = r_count + CW'(1);
                        n_carry = VW'(i_value);
                        n_start = PW'(r_count - CW'(1));
                        n_span  = SPW'(2);
                        n_k     = KW'(1);
                        n_rbase = '0;
                        if (r_count != '0) begin
                            n_state = S_ALVL;
                        end
                    end
                end
            end
            S_ALVL: begin
                mem_we    = 1'b1;
                mem_waddr = wbase + AW'(r_start);
                mem_wdata = lvl_min;
                mem_raddr = wbase + AW'(start_diff);
                n_carry   = lvl_min;
                n_rbase   = wbase;
                n_start   = PW'(start_diff);
                n_span    = r_span << 1;
                n_k       = r_k + KW'(1);
                if (!lvl_more) begin
                    n_state = S_IDLE;
                end
            end
            S_QDEC: begin
                n_lo    = qd_lo;
                n_sec   = qd_sec;
                n_qk    = qd_k;
                n_qerr  = qd_err;
                n_state = S_QRD1;
            end
            S_QRD1: begin
                mem_raddr = kbase + AW'(r_lo);
                if (r_qerr) begin
                    n_carry = '0;
                    n_state = S_QOUT;
                end else begin
                    n_state = S_QRD2;
                end
            end
            S_QRD2: begin
                mem_raddr = kbase + AW'(r_sec);
                n_carry   = mem_rdata;
                n_state   = S_QMIN;
            end
            S_QMIN: begin
                n_carry = lvl_min;
                n_state = S_QOUT;
            end
            S_QOUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_min_value   = OUT_W'(r_carry);
                    n_range_error = r_qerr;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start       <= n_start;
        r_span        <= n_span;
        r_k           <= n_k;
        r_rbase       <= n_rbase;
        r_carry       <= n_carry;
        r_a           <= n_a;
        r_b           <= n_b;
        r_lo          <= n_lo;
        r_sec         <= n_sec;
        r_qk          <= n_qk;
        r_qerr        <= n_qerr;
        r_min_value   <= n_min_value;
        r_range_error <= n_range_error;
    end

    assign o_out_valid   = r_out_valid;
    assign o_min_value   = r_min_value;
    assign o_range_error = r_range_error;

endmodule

### rtl/stb_chk.sv
// Port-level checker for the sparse-table range-minimum engine, bound to the top level.
// Uses stb_pkg for the command codes.
module stb_chk
    import stb_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             i_cmd,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [OUT_W-1:0] o_min_value,
    input logic             o_range_error
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Result transaction withdrawn before acceptance.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_min_value) && $stable(o_range_error))
        else $error("Result payload changed while stalled.");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_error |-> o_min_value == '0)
        else $error("Range error reported with a non-zero minimum.");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (t_cmd'(i_cmd) == CMD_QUERY) |=> !o_in_ready)
        else $error("Input ready straight after a query transaction.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result valid directly after reset.");

endmodule

bind sparse_table_range_min stb_chk u_stb_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_cmd        (i_cmd),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_min_value  (o_min_value),
    .o_range_error(o_range_error)
);
